// ----- hw/rtl/fqkr_pkg.sv -----
// Package for the keyed-removal thread queue.
// Holds the operation and status codes and the control struct shared by the queue and its cells.
package fqkr_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int STATUS_BITS = 2;
    localparam int ID_OUT_BITS = 16;
    localparam int OCC_BITS    = 5;

    // Broadcast control from the queue controller to every cell.
    typedef struct packed {
        logic capture;    // latch the compare result against the incoming key
        logic shift_all;  // every cell takes its newer neighbor's id
        logic shift_tail; // only cells at or above the newest match shift
    } t_cell_ctl;

endpackage

// ----- hw/rtl/fqkr_cell.sv -----
// One storage cell of the keyed-removal thread queue.
// Depends on fqkr_pkg for the control struct; holds one id and its latched match flag.
module fqkr_cell
    import fqkr_pkg::*;
#(
    parameter int ID_BITS = 16
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_valid,
    input  logic [ID_BITS-1:0] i_key,
    input  logic               i_load,
    input  logic [ID_BITS-1:0] i_next_id,
    input  logic               i_or_above,
    output logic [ID_BITS-1:0] o_id,
    output logic               o_match,
    output logic               o_or
);

    logic [ID_BITS-1:0] r_id;
    logic               r_match;
    logic               shift;

    // A cell at or above the newest match sees no match in any newer cell.
    assign shift = i_ctl.shift_all | (i_ctl.shift_tail & ~i_or_above);

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= i_valid & (r_id == i_key);
        end
        if (i_load) begin
            r_id <= i_key;
        end else if (shift) begin
            r_id <= i_next_id;
        end
    end

    assign o_id    = r_id;
    assign o_match = r_match;
    assign o_or    = r_match | i_or_above;

endmodule

// ----- hw/rtl/fifo_queue_with_keyed_removal.sv -----
// Keyed-removal thread queue: a row of cells kept oldest first, cell 0 the oldest.
// Each accepted beat is handled in turn: first the cells compare against the key, then the row
// shifts and the result strobe is raised; busy is high in between, so no new beat is taken until it is done.
// The rippled match chain across the cells sets the path of the shift step.
// Synchronous active-low reset empties the queue; results cannot be stalled by the receiver.
module fifo_queue_with_keyed_removal
    import fqkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic [15:0]            i_thread_id,
    output logic                   o_strobe,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [ID_OUT_BITS-1:0] o_id_out,
    output logic [OCC_BITS-1:0]    o_occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic               r_busy, n_busy;
    logic               r_strobe, n_strobe;
    logic [CW-1:0]      r_count, n_count;
    logic [1:0]         r_mode;
    logic [ID_BITS-1:0] r_key;
    logic [1:0]         r_status, n_status;
    logic [ID_BITS-1:0] r_id, n_id;

    logic               accept;
    logic [ID_BITS-1:0] key_in;
    logic [ID_BITS-1:0] cell_key;
    t_cell_ctl          ctl;
    logic               load_en;

    logic [ID_BITS-1:0] cell_id  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [QUEUE_DEPTH-1:0] cell_or;

    assign accept   = start & ~r_busy;
    assign key_in   = ID_BITS'(i_thread_id);
    // During capture the cells see the incoming key, afterwards the held one.
    assign cell_key = r_busy ? r_key : key_in;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic               valid;
            logic               load;
            logic [ID_BITS-1:0] next_id;
            logic               or_above;

            assign valid = CW'(g) < r_count;
            assign load  = load_en & (r_count == CW'(g));
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign next_id  = '0;
                assign or_above = 1'b0;
            end else begin : g_mid
                assign next_id  = cell_id[g+1];
                assign or_above = cell_or[g+1];
            end

            fqkr_cell #(
                .ID_BITS(ID_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_valid    (valid),
                .i_key      (cell_key),
                .i_load     (load),
                .i_next_id  (next_id),
                .i_or_above (or_above),
                .o_id       (cell_id[g]),
                .o_match    (cell_match[g]),
                .o_or       (cell_or[g])
            );
        end
    endgenerate

    always_comb begin
        ctl.capture    = accept;
        ctl.shift_all  = 1'b0;
        ctl.shift_tail = 1'b0;
        load_en        = 1'b0;
        n_busy         = accept;
        n_strobe       = r_busy;
        n_count        = r_count;
        n_status       = r_status;
        n_id           = r_id;

        if (r_busy) begin
            n_status = ST_OK;
            n_id     = r_key;
            unique case (r_mode)
                MODE_INSERT: begin
                    if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        load_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                MODE_POP: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_id          = cell_id[0];
                        ctl.shift_all = 1'b1;
                        n_count       = r_count - 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    // The oldest entry wins if it matches, otherwise the newest match goes.
                    if (cell_match[0]) begin
                        ctl.shift_all = 1'b1;
                        n_count       = r_count - 1'b1;
                    end else if (cell_or[0]) begin
                        ctl.shift_tail = 1'b1;
                        n_count        = r_count - 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                MODE_LOOKUP: begin
                    if (!cell_or[0]) begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    n_status = ST_NOT_FOUND;
                end
            endcase
            if (n_status != ST_OK) begin
                n_id = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= key_in;
        end
        r_status <= n_status;
        r_id     <= n_id;
    end

    assign busy        = r_busy;
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_id_out    = ID_OUT_BITS'(r_id);
    assign o_occupancy = OCC_BITS'(r_count);

endmodule

// ----- hw/rtl/fqkr_check.sv -----
// Port-level checker for the keyed-removal thread queue, bound to the top level.
// Depends on fqkr_pkg for the status codes.
module fqkr_check
    import fqkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_strobe,
    input logic [STATUS_BITS-1:0] o_status,
    input logic [ID_OUT_BITS-1:0] o_id_out,
    input logic [OCC_BITS-1:0]    o_occupancy
);

    // Every accepted beat is followed by its result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("accepted beat produced no result");

    a_strobe_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a beat in flight");

    a_id_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_id_out == '0))
        else $error("id not zero on a failed operation");

    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_occupancy) <= QUEUE_DEPTH))
        else $error("occupancy above queue depth");

endmodule

bind fifo_queue_with_keyed_removal fqkr_check #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_fqkr_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_status    (o_status),
    .o_id_out    (o_id_out),
    .o_occupancy (o_occupancy)
);

// ----- tb/sv/tb_fifo_queue_with_keyed_removal.sv -----
// Self-checking testbench for the keyed-removal thread queue: directed corner beats, then
// phased random insert/pop/remove/lookup traffic, each result checked against a queue model.
// Depends on fqkr_pkg and fifo_queue_with_keyed_removal only.
module tb_fifo_queue_with_keyed_removal;
    import fqkr_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_BEATS   = 1825;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int QUIET_FIRST    = 700;
    localparam int QUIET_LAST     = 1000;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] tid;
        bit          drain;   // sender waits here until every result is back
    } t_queue_op;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [ID_OUT_BITS-1:0] id;
        logic [OCC_BITS-1:0]    occ;
    } t_queue_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             i_mode = MODE_INSERT;
    logic [15:0]            i_thread_id = '0;
    logic                   o_strobe;
    logic [STATUS_BITS-1:0] o_status;
    logic [ID_OUT_BITS-1:0] o_id_out;
    logic [OCC_BITS-1:0]    o_occupancy;

    t_queue_op     pending_ops[$];
    t_queue_result expected_results[$];
    logic [15:0]   queued_ids[$];     // model of the store, oldest first
    int            sent_beats = 0;
    int            result_beats = 0;
    int            error_count = 0;
    int            cycle_count = 0;

    logic [15:0] key_pool [0:9] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555,
                                    16'hAAAA, 16'h00FF, 16'hFF00, 16'h1234, 16'h0F0F};

    fifo_queue_with_keyed_removal u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_thread_id (i_thread_id),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_id_out    (o_id_out),
        .o_occupancy (o_occupancy)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Position of the newest queued entry equal to key, or -1.
    function automatic int newest_position(logic [15:0] key);
        for (int i = queued_ids.size() - 1; i >= 0; i--) begin
            if (queued_ids[i] == key) return i;
        end
        return -1;
    endfunction

    // Applies one operation to the queue model and returns the result it produces.
    function automatic t_queue_result apply_queue_op(logic [1:0] mode, logic [15:0] key);
        t_queue_result r;
        int pos;
        r.status = ST_OK;
        r.id = '0;
        case (mode)
            MODE_INSERT: begin
                if (queued_ids.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    queued_ids.push_back(key);
                    r.id = key;
                end
            end
            MODE_POP: begin
                if (queued_ids.size() == 0) r.status = ST_EMPTY;
                else r.id = queued_ids.pop_front();
            end
            MODE_REMOVE: begin
                // The oldest entry wins if it matches; otherwise the newest match goes.
                if (queued_ids.size() == 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (queued_ids[0] == key) begin
                    void'(queued_ids.pop_front());
                    r.id = key;
                end else begin
                    pos = newest_position(key);
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        queued_ids.delete(pos);
                        r.id = key;
                    end
                end
            end
            default: begin
                if (newest_position(key) < 0) r.status = ST_NOT_FOUND;
                else r.id = key;
            end
        endcase
        r.occ = OCC_BITS'(queued_ids.size());
        return r;
    endfunction

    task automatic add_op(logic [1:0] mode, logic [15:0] tid);
        t_queue_op op;
        op.mode = mode;
        op.tid = tid;
        op.drain = 1'b0;
        pending_ops.push_back(op);
    endtask

    task automatic add_drain();
        t_queue_op op;
        op.mode = MODE_LOOKUP;
        op.tid = '0;
        op.drain = 1'b1;
        pending_ops.push_back(op);
    endtask

    // Driver: a beat is taken at an edge where start is high and busy is low.
    always @(posedge i_clk) begin
        bit        taken;
        bit        go;
        t_queue_op op;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            go = 1'b0;
            if (taken) begin
                expected_results.push_back(apply_queue_op(i_mode, i_thread_id));
                sent_beats++;
            end
            if (!(start && !taken)) begin
                if (pending_ops.size() > 0) begin
                    if (pending_ops[0].drain) begin
                        if (!taken && expected_results.size() == 0) begin
                            void'(pending_ops.pop_front());
                        end
                    end else if ((sent_beats >= QUIET_FIRST && sent_beats < QUIET_LAST) ||
                                 $urandom_range(0, 99) >= 30) begin
                        op = pending_ops.pop_front();
                        go = 1'b1;
                        i_mode <= op.mode;
                        i_thread_id <= op.tid;
                    end
                end
                start <= go;
            end
        end
    end

    // Monitor: each strobed beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_queue_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result: status %0d id %h occupancy %0d",
                             o_status, o_id_out, o_occupancy);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status || o_id_out !== exp_r.id ||
                    o_occupancy !== exp_r.occ) begin
                    if (error_count < 10)
                        $display("result %0d mismatch: expected status %0d id %h occupancy %0d,",
                                 result_beats, exp_r.status, exp_r.id, exp_r.occ,
                                 " got status %0d id %h occupancy %0d",
                                 o_status, o_id_out, o_occupancy);
                    error_count++;
                end
            end
            result_beats++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[fifo_queue_with_keyed_removal] ERROR");
            $finish;
        end
    end

    initial begin
        int          pick;
        logic [1:0]  mode;
        logic [15:0] tid;
        bit          filling;

        // Empty queue corners.
        add_op(MODE_POP, 16'h0005);
        add_op(MODE_REMOVE, 16'h0005);
        add_op(MODE_LOOKUP, 16'h0005);
        // Fill to the brim with duplicates near the head.
        add_op(MODE_INSERT, 16'h0000);
        add_op(MODE_INSERT, 16'hFFFF);
        add_op(MODE_INSERT, 16'h1234);
        add_op(MODE_INSERT, 16'h0000);
        add_op(MODE_INSERT, 16'h1234);
        for (int k = 0; k < 11; k++) add_op(MODE_INSERT, 16'h0100 + 16'(k));
        add_op(MODE_INSERT, 16'hBEEF);   // refused, queue full
        add_op(MODE_LOOKUP, 16'hFFFF);
        add_op(MODE_REMOVE, 16'h0000);   // oldest entry matches
        add_op(MODE_REMOVE, 16'h1234);   // duplicate not at the head: newest one goes
        add_op(MODE_REMOVE, 16'hABCD);   // absent
        add_op(MODE_POP, 16'h0000);
        add_op(MODE_LOOKUP, 16'h1234);
        add_drain();

        // Random traffic in alternating fill-heavy and drain-heavy phases.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 30 == 0) filling = ~filling;
            pick = $urandom_range(0, 99);
            if (filling)
                mode = (pick < 55) ? MODE_INSERT : (pick < 70) ? MODE_POP :
                       (pick < 85) ? MODE_REMOVE : MODE_LOOKUP;
            else
                mode = (pick < 15) ? MODE_INSERT : (pick < 50) ? MODE_POP :
                       (pick < 80) ? MODE_REMOVE : MODE_LOOKUP;
            if ($urandom_range(0, 99) < 60) tid = key_pool[$urandom_range(0, 9)];
            else tid = 16'($urandom);
            add_op(mode, tid);
            if (n == 900) add_drain();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[fifo_queue_with_keyed_removal] OK");
        end else begin
            $display("[fifo_queue_with_keyed_removal] ERROR");
        end
        $finish;
    end

endmodule
